### sv/otfp_pkg.sv
// ----------------------------------------------------------------------------
// otfp_pkg
// Widths, character codes, line layout and tick constants shared by the
// time-overlay line parser, its channels and its checker.
// ----------------------------------------------------------------------------
package otfp_pkg;

    localparam int CHAR_W   = 8;
    localparam int DAY_W    = 62;
    localparam int TS_W     = 63;
    localparam int FNO_W    = 27;
    localparam int SATS_W   = 4;
    localparam int FIX_W    = 8;
    localparam int FSTATE_W = 2;
    localparam int FLAGS_W  = 7;
    localparam int POS_W    = 5;
    localparam int HMS_W    = 7;   // two decimal digits
    localparam int MS_W     = 14;  // four decimal digits
    localparam int TOD_W    = 42;  // time of day in ticks, up to 99:99:99.9999

    // character positions within one line
    localparam logic [POS_W-1:0] POS_FIX       = 5'd0;
    localparam logic [POS_W-1:0] POS_SATS      = 5'd1;
    localparam logic [POS_W-1:0] POS_WAIT      = 5'd2;
    localparam logic [POS_W-1:0] POS_HOUR0     = 5'd3;
    localparam logic [POS_W-1:0] POS_HOUR1     = 5'd4;
    localparam logic [POS_W-1:0] POS_MIN0      = 5'd5;
    localparam logic [POS_W-1:0] POS_MIN1      = 5'd6;
    localparam logic [POS_W-1:0] POS_SEC0      = 5'd7;
    localparam logic [POS_W-1:0] POS_SEC1      = 5'd8;
    localparam logic [POS_W-1:0] POS_MS1_FIRST = 5'd9;
    localparam logic [POS_W-1:0] POS_MS1_LAST  = 5'd12;
    localparam logic [POS_W-1:0] POS_MS2_FIRST = 5'd13;
    localparam logic [POS_W-1:0] POS_MS2_LAST  = 5'd16;
    localparam logic [POS_W-1:0] POS_FNO_FIRST = 5'd17;
    localparam logic [POS_W-1:0] POS_LAST      = 5'd24;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_WAIT  = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CHAR_G     = 8'h47;

    // fix state codes
    localparam logic [FSTATE_W-1:0] FIX_NONE     = 2'd0;
    localparam logic [FSTATE_W-1:0] FIX_INTERNAL = 2'd1;
    localparam logic [FSTATE_W-1:0] FIX_GFIX     = 2'd2;
    localparam logic [FSTATE_W-1:0] FIX_PFIX     = 2'd3;

    // error flag bit positions
    localparam int ERR_SATS = 0;
    localparam int ERR_WAIT = 1;
    localparam int ERR_HOUR = 2;
    localparam int ERR_MIN  = 3;
    localparam int ERR_MS   = 4;
    localparam int ERR_FNO  = 5;
    localparam int ERR_SEC  = 6;

    // 100 ns ticks
    localparam logic [TOD_W-1:0] TICKS_HOUR     = 42'd36000000000;
    localparam logic [TOD_W-1:0] TICKS_MINUTE   = 42'd600000000;
    localparam logic [TOD_W-1:0] TICKS_SECOND   = 42'd10000000;
    localparam logic [TOD_W-1:0] TICKS_TENTH_MS = 42'd1000;
    localparam logic [TS_W-1:0]  TICKS_DAY      = 63'd864000000000;

    typedef struct packed {
        logic [FIX_W-1:0]  fix;
        logic [SATS_W-1:0] sats;
        logic              almanac;
        logic              sats_bad;
        logic              wait_bad;
        logic              hour_bad;
        logic              min_bad;
        logic              sec_bad;
        logic              ms1_bad;
        logic              ms2_bad;
    } pending_t;

    typedef struct packed {
        logic started;
        logic gap;
        logic bad;
    } fno_mark_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        diff = c - CHAR_ZERO;
        return diff[3:0];
    endfunction

endpackage

### sv/otfp_char_if.sv
// ----------------------------------------------------------------------------
// otfp_char_if
// Character channel: one recognized character with the day start ticks.
// ----------------------------------------------------------------------------
interface otfp_char_if;

    logic                          valid;
    logic                          ready;
    logic [otfp_pkg::CHAR_W-1:0]   char_code;
    logic [otfp_pkg::DAY_W-1:0]    day_ticks;

    modport source (output valid, char_code, day_ticks, input ready);
    modport sink   (input valid, char_code, day_ticks, output ready);

endinterface

### sv/otfp_field_if.sv
// ----------------------------------------------------------------------------
// otfp_field_if
// Result channel: one parsed time-overlay line.
// ----------------------------------------------------------------------------
interface otfp_field_if;

    logic                            valid;
    logic                            ready;
    logic [otfp_pkg::TS_W-1:0]       field_timestamp;
    logic [otfp_pkg::FNO_W-1:0]      field_number;
    logic [otfp_pkg::SATS_W-1:0]     satellites;
    logic                            almanac_state;
    logic [otfp_pkg::FIX_W-1:0]      fix_type;
    logic [otfp_pkg::FSTATE_W-1:0]   fix_state;
    logic                            ok;
    logic [otfp_pkg::FLAGS_W-1:0]    error_flags;

    modport source (output valid, field_timestamp, field_number, satellites, almanac_state,
                    fix_type, fix_state, ok, error_flags, input ready);
    modport sink   (input valid, field_timestamp, field_number, satellites, almanac_state,
                    fix_type, fix_state, ok, error_flags, output ready);

endinterface

### sv/osd_timestamp_field_parser_unit.sv
// ----------------------------------------------------------------------------
// osd_timestamp_field_parser_unit
// Parses the 25 characters of a time-overlay line into a timestamp, field
// number, satellite count, almanac and fix state and error flags.
// ----------------------------------------------------------------------------
// throughput: one character item per cycle while the result output is not
// stalled, no bubbles between lines; the result is registered as the 25th character is accepted
// the time of day is summed up at positions 9 and 17, so the last character
// only adds the day start and the rollover day
// reset clears the character position, the hour-23 rollover memory and the
// result valid; a new line must start at position 0
// ----------------------------------------------------------------------------
module osd_timestamp_field_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    otfp_char_if.sink            chars,
    otfp_field_if.source         fields
);

    logic                                accept;
    logic [otfp_pkg::CHAR_W-1:0]         c;
    logic                                c_digit;
    logic [3:0]                          dv;

    logic [otfp_pkg::POS_W-1:0]          pos_reg, pos_next;
    otfp_pkg::pending_t                  pend_reg, pend_next;
    logic [otfp_pkg::HMS_W-1:0]          hour_reg, hour_next;
    logic [otfp_pkg::HMS_W-1:0]          min_reg, min_next;
    logic [otfp_pkg::HMS_W-1:0]          sec_reg, sec_next;
    logic [otfp_pkg::MS_W-1:0]           ms1_reg, ms1_next;
    logic [otfp_pkg::MS_W-1:0]           ms2_reg, ms2_next;
    logic [otfp_pkg::FNO_W-1:0]          fno_reg, fno_next;
    otfp_pkg::fno_mark_t                 mark_reg, mark_next;
    logic [otfp_pkg::TOD_W-1:0]          tod_reg, tod_next;
    logic [otfp_pkg::DAY_W-1:0]          h23_ticks_reg, h23_ticks_next;
    logic                                h23_armed_reg, h23_armed_next;

    logic [otfp_pkg::HMS_W-1:0]          hh_eff, mm_eff, ss_eff;
    logic [otfp_pkg::MS_W-1:0]           ms_eff;
    logic                                last_char;
    logic                                rollover;
    logic                                success;
    logic                                alm;
    logic [otfp_pkg::FLAGS_W-1:0]        flags;
    logic [otfp_pkg::FSTATE_W-1:0]       fstate;
    logic [otfp_pkg::TS_W-1:0]           ts;

    logic                                out_valid_reg;
    logic [otfp_pkg::TS_W-1:0]           ts_reg;
    logic [otfp_pkg::FNO_W-1:0]          out_fno_reg;
    logic [otfp_pkg::SATS_W-1:0]         sats_reg;
    logic                                alm_reg;
    logic [otfp_pkg::FIX_W-1:0]          fix_reg;
    logic [otfp_pkg::FSTATE_W-1:0]       fstate_reg;
    logic                                ok_reg;
    logic [otfp_pkg::FLAGS_W-1:0]        flags_reg;

    assign chars.ready = !out_valid_reg || fields.ready;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.char_code;
    assign c_digit     = otfp_pkg::is_digit(c);
    assign dv          = otfp_pkg::digit_value(c);
    assign last_char   = (pos_reg == otfp_pkg::POS_LAST);

    assign pos_next = last_char ? '0 : otfp_pkg::POS_W'(pos_reg + 1'b1);

    // effective field values, failed fields count as zero
    assign hh_eff = pend_reg.hour_bad ? '0 : hour_reg;
    assign mm_eff = pend_reg.min_bad  ? '0 : min_reg;
    assign ss_eff = pend_reg.sec_bad  ? '0 : sec_reg;
    assign ms_eff = !pend_reg.ms1_bad ? ms1_reg : (!pend_reg.ms2_bad ? ms2_reg : '0);

    // per-character field collection
    always_comb
    begin
        pend_next = pend_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        ms1_next  = ms1_reg;
        ms2_next  = ms2_reg;
        fno_next  = fno_reg;
        mark_next = mark_reg;
        unique case (pos_reg) inside
            otfp_pkg::POS_FIX:
            begin
                pend_next     = '0;
                pend_next.fix = c;
                hour_next     = '0;
                min_next      = '0;
                sec_next      = '0;
                ms1_next      = '0;
                ms2_next      = '0;
                fno_next      = '0;
                mark_next     = '0;
            end
            otfp_pkg::POS_SATS:
            begin
                if (c_digit)
                    pend_next.sats = dv;
                else
                    pend_next.sats_bad = 1'b1;
            end
            otfp_pkg::POS_WAIT:
            begin
                if (c == otfp_pkg::CHAR_SPACE || c == otfp_pkg::CHAR_NUL)
                    pend_next.almanac = 1'b1;
                else if (c != otfp_pkg::CHAR_WAIT)
                    pend_next.wait_bad = 1'b1;
            end
            [otfp_pkg::POS_HOUR0:otfp_pkg::POS_HOUR1]:
            begin
                if (c_digit)
                    hour_next = otfp_pkg::HMS_W'(hour_reg * 7'd10 + 7'(dv));
                else
                    pend_next.hour_bad = 1'b1;
            end
            [otfp_pkg::POS_MIN0:otfp_pkg::POS_MIN1]:
            begin
                if (c_digit)
                    min_next = otfp_pkg::HMS_W'(min_reg * 7'd10 + 7'(dv));
                else
                    pend_next.min_bad = 1'b1;
            end
            [otfp_pkg::POS_SEC0:otfp_pkg::POS_SEC1]:
            begin
                if (c_digit)
                    sec_next = otfp_pkg::HMS_W'(sec_reg * 7'd10 + 7'(dv));
                else
                    pend_next.sec_bad = 1'b1;
            end
            [otfp_pkg::POS_MS1_FIRST:otfp_pkg::POS_MS1_LAST]:
            begin
                if (c_digit)
                    ms1_next = otfp_pkg::MS_W'(ms1_reg * 14'd10 + 14'(dv));
                else
                    pend_next.ms1_bad = 1'b1;
            end
            [otfp_pkg::POS_MS2_FIRST:otfp_pkg::POS_MS2_LAST]:
            begin
                if (c_digit)
                    ms2_next = otfp_pkg::MS_W'(ms2_reg * 14'd10 + 14'(dv));
                else
                    pend_next.ms2_bad = 1'b1;
            end
            default:
            begin
                // field number: one run of digits, blanks only around it
                if (!mark_reg.bad)
                begin
                    if (c != otfp_pkg::CHAR_NUL && c != otfp_pkg::CHAR_SPACE)
                    begin
                        if (mark_reg.gap || !c_digit)
                        begin
                            mark_next     = '0;
                            mark_next.bad = 1'b1;
                        end
                        else
                        begin
                            fno_next = otfp_pkg::FNO_W'(fno_reg * 27'd10 + 27'(dv));
                            mark_next.started = 1'b1;
                        end
                    end
                    else if (mark_reg.started)
                    begin
                        mark_next.gap = 1'b1;
                    end
                end
            end
        endcase
    end

    // time of day: hours, minutes, seconds once they are complete, then ms
    always_comb
    begin
        tod_next = tod_reg;
        if (pos_reg == otfp_pkg::POS_MS1_FIRST)
            tod_next = otfp_pkg::TOD_W'(hh_eff) * otfp_pkg::TICKS_HOUR
                     + otfp_pkg::TOD_W'(mm_eff) * otfp_pkg::TICKS_MINUTE
                     + otfp_pkg::TOD_W'(ss_eff) * otfp_pkg::TICKS_SECOND;
        else if (pos_reg == otfp_pkg::POS_FNO_FIRST)
            tod_next = tod_reg + otfp_pkg::TOD_W'(ms_eff) * otfp_pkg::TICKS_TENTH_MS;
    end

    // result of the last character
    always_comb
    begin
        flags = '0;
        flags[otfp_pkg::ERR_SATS] = pend_reg.sats_bad;
        flags[otfp_pkg::ERR_WAIT] = pend_reg.wait_bad;
        flags[otfp_pkg::ERR_HOUR] = pend_reg.hour_bad;
        flags[otfp_pkg::ERR_MIN]  = pend_reg.min_bad;
        flags[otfp_pkg::ERR_MS]   = pend_reg.ms1_bad && pend_reg.ms2_bad;
        flags[otfp_pkg::ERR_SEC]  = pend_reg.sec_bad;
        // a failed field number reports only its own flag
        if (!mark_next.started)
        begin
            flags = '0;
            flags[otfp_pkg::ERR_FNO] = 1'b1;
        end
    end

    assign success  = (flags == '0);
    assign rollover = (hh_eff == '0) && (h23_ticks_reg == chars.day_ticks);
    assign ts       = otfp_pkg::TS_W'(chars.day_ticks) + otfp_pkg::TS_W'(tod_reg)
                    + (rollover ? otfp_pkg::TICKS_DAY : '0);
    assign alm      = !pend_reg.wait_bad && pend_reg.almanac;

    always_comb
    begin
        if (!alm && (pend_reg.fix == otfp_pkg::CHAR_P || pend_reg.fix == otfp_pkg::CHAR_G))
            fstate = otfp_pkg::FIX_INTERNAL;
        else if (alm && pend_reg.fix == otfp_pkg::CHAR_G)
            fstate = otfp_pkg::FIX_GFIX;
        else if (alm && pend_reg.fix == otfp_pkg::CHAR_P)
            fstate = otfp_pkg::FIX_PFIX;
        else
            fstate = otfp_pkg::FIX_NONE;
    end

    // hour-23 memory for the midnight rollover, only on clean lines
    always_comb
    begin
        h23_ticks_next = h23_ticks_reg;
        h23_armed_next = h23_armed_reg;
        if (last_char && success)
        begin
            if (hh_eff == 7'd23 && !h23_armed_reg && h23_ticks_reg != chars.day_ticks)
            begin
                h23_ticks_next = chars.day_ticks;
                h23_armed_next = 1'b1;
            end
            else if (hh_eff == '0 && h23_armed_reg)
            begin
                h23_armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pend_reg      <= '0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            ms1_reg       <= '0;
            ms2_reg       <= '0;
            fno_reg       <= '0;
            mark_reg      <= '0;
            tod_reg       <= '0;
            h23_ticks_reg <= '0;
            h23_armed_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            hour_reg      <= hour_next;
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            ms1_reg       <= ms1_next;
            ms2_reg       <= ms2_next;
            fno_reg       <= fno_next;
            mark_reg      <= mark_next;
            tod_reg       <= tod_next;
            h23_ticks_reg <= h23_ticks_next;
            h23_armed_reg <= h23_armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && last_char)
            out_valid_reg <= 1'b1;
        else if (fields.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            ts_reg      <= ts;
            out_fno_reg <= fno_next;
            sats_reg    <= pend_reg.sats;
            alm_reg     <= alm;
            fix_reg     <= pend_reg.fix;
            fstate_reg  <= fstate;
            ok_reg      <= success;
            flags_reg   <= flags;
        end
    end

    assign fields.valid           = out_valid_reg;
    assign fields.field_timestamp = ts_reg;
    assign fields.field_number    = out_fno_reg;
    assign fields.satellites      = sats_reg;
    assign fields.almanac_state   = alm_reg;
    assign fields.fix_type        = fix_reg;
    assign fields.fix_state       = fstate_reg;
    assign fields.ok              = ok_reg;
    assign fields.error_flags     = flags_reg;

endmodule

### sv/otfp_checker.sv
// ----------------------------------------------------------------------------
// otfp_checker
// Port-level checks of the time-overlay line parser, bound to the top level.
// ----------------------------------------------------------------------------
module otfp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [otfp_pkg::TS_W-1:0]        field_timestamp,
    input logic [otfp_pkg::SATS_W-1:0]      satellites,
    input logic [otfp_pkg::FIX_W-1:0]       fix_type,
    input logic [otfp_pkg::FSTATE_W-1:0]    fix_state,
    input logic                             ok,
    input logic [otfp_pkg::FLAGS_W-1:0]     error_flags
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_timestamp))
        else $error("result changed while stalled");

    // a new result only follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ok == (error_flags == '0))
                      && (!error_flags[otfp_pkg::ERR_FNO] || $onehot(error_flags)))
        else $error("ok and error flags disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fix_state != otfp_pkg::FIX_NONE
            |-> fix_type == otfp_pkg::CHAR_P || fix_type == otfp_pkg::CHAR_G)
        else $error("fix state without a fix type");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> satellites <= otfp_pkg::SATS_W'(9))
        else $error("satellites out of range");

endmodule

bind osd_timestamp_field_parser_unit otfp_checker u_otfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (chars.valid),
    .in_ready        (chars.ready),
    .out_valid       (fields.valid),
    .out_ready       (fields.ready),
    .field_timestamp (fields.field_timestamp),
    .satellites      (fields.satellites),
    .fix_type        (fields.fix_type),
    .fix_state       (fields.fix_state),
    .ok              (fields.ok),
    .error_flags     (fields.error_flags)
);
